// ===== hw/rtl/hieq_pkg.sv =====
// ----------------------------------------------------------------------------
// hieq_pkg
// shared types, sizes and helpers of the histogram equalizer
// ----------------------------------------------------------------------------
package hieq_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int PIX_BITS    = 8;
    localparam int BIN_BITS    = 8;
    localparam int BIN_COUNT   = 256;
    localparam int NUM_LANES   = 3;
    localparam int DATA_BITS   = NUM_LANES * PIX_BITS;
    localparam int CUM_BITS    = COUNT_BITS + BIN_BITS;
    localparam int NUM_BITS    = CUM_BITS + PIX_BITS;
    localparam int QUO_STEPS   = PIX_BITS + 1;
    localparam int STEP_BITS   = $clog2(QUO_STEPS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [BIN_BITS-1:0]   BIN_LAST  = BIN_BITS'(BIN_COUNT - 1);

    // mean of three channels: floor((2*sum+1)/6) by reciprocal
    localparam int SUM_BITS    = PIX_BITS + 2;
    localparam int ODD_BITS    = SUM_BITS + 1;
    localparam int RECIP_SHIFT = 13;
    localparam int RECIP_BITS  = 11;
    localparam logic [RECIP_BITS-1:0] RECIP_SIX = RECIP_BITS'(1366);

    typedef enum logic [0:0] {
        OP_COUNT = 1'b0,
        OP_MAP   = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_BUILD,
        ST_MAP
    } state_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_READ,
        BS_ACC,
        BS_SCALE,
        BS_DIV
    } bld_state_t;

    typedef struct packed {
        logic cnt_rd;
        logic cnt_wr;
        logic build_start;
    } hist_ctrl_t;

    typedef struct packed {
        logic build_done;
        logic overflow;
    } hist_stat_t;

    typedef struct packed {
        logic                we;
        logic [BIN_BITS-1:0] addr;
        logic [PIX_BITS-1:0] data;
    } tbl_wr_t;

    function automatic logic [BIN_BITS-1:0] color_bin(
        input logic [PIX_BITS-1:0] c0,
        input logic [PIX_BITS-1:0] c1,
        input logic [PIX_BITS-1:0] c2
    );
        logic [SUM_BITS-1:0]            sum;
        logic [ODD_BITS-1:0]            odd;
        logic [ODD_BITS+RECIP_BITS-1:0] prod;
        sum  = SUM_BITS'(c0) + SUM_BITS'(c1) + SUM_BITS'(c2);
        odd  = {sum, 1'b1};
        prod = (ODD_BITS+RECIP_BITS)'(odd) * (ODD_BITS+RECIP_BITS)'(RECIP_SIX);
        return prod[RECIP_SHIFT +: BIN_BITS];
    endfunction

endpackage

// ===== hw/rtl/histogram_equalizer_unit.sv =====
// ----------------------------------------------------------------------------
// histogram_equalizer_unit
// two-pass 8-bit histogram equalizer: count pass builds a 256-bin histogram,
// the last counted item builds the transfer table, map pass looks pixels up
// ----------------------------------------------------------------------------
// channel  direction  tdata (low bit up)      tlast     tuser
// s_       in         chan0, chan1, chan2     last      opcode
// m_       out        out0, out1, out2        out_last  count_overflow
// cfg_     in         cfg_wr_data = color_mode, written when cfg_wr_en is high
//
// count item: accept, bin read, saturating increment write
// map item: accept with table read, then output load once the output register
//   drains; three table copies are read in parallel, one per channel
// last count item adds the table build: per bin the build sequencer reads,
//   accumulates and scales, then runs the shared divider, for all 256 bins
// reset (aresetn low, synchronous) clears the histogram valid bits, the
//   pixel total, the overflow flag and color_mode; the table is unwritten
// a stalled result holds in the output register while the next item is taken
// ----------------------------------------------------------------------------
module histogram_equalizer_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,  // color_mode
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hieq_pkg::DATA_BITS-1:0]  s_tdata,      // chan0, chan1, chan2
    input  logic                            s_tlast,      // last
    input  logic                            s_tuser,      // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hieq_pkg::DATA_BITS-1:0]  m_tdata,      // out0, out1, out2
    output logic                            m_tlast,      // out_last
    output logic                            m_tuser       // count_overflow
);
    import hieq_pkg::*;

    state_t                              state_reg, state_next;
    logic                                mode_reg;
    logic [BIN_BITS-1:0]                 bin_reg;
    logic                                last_reg;
    logic                                m_valid_reg;
    logic [DATA_BITS-1:0]                m_data_reg;
    logic                                m_last_reg;
    logic                                m_user_reg;

    logic                                accept;
    logic                                is_map;
    logic                                map_go;
    logic                                out_free;
    logic                                out_load;
    logic [BIN_BITS-1:0]                 bin_calc;
    hist_ctrl_t                          hctrl;
    hist_stat_t                          hstat;
    tbl_wr_t                             twr;
    logic [NUM_LANES-1:0][PIX_BITS-1:0]  lane_addr;
    logic [NUM_LANES-1:0][PIX_BITS-1:0]  lane_out;
    logic [NUM_LANES-1:0]                lane_use;

    assign accept    = s_tvalid && s_tready;
    assign is_map    = (opcode_t'(s_tuser) == OP_MAP);
    assign out_free  = !m_valid_reg || m_tready;
    assign lane_addr = s_tdata;
    assign bin_calc  = mode_reg ? color_bin(s_tdata[0 +: PIX_BITS],
                                            s_tdata[PIX_BITS +: PIX_BITS],
                                            s_tdata[2*PIX_BITS +: PIX_BITS])
                                : s_tdata[0 +: PIX_BITS];

    hieq_hist u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (hctrl),
        .bin     (bin_reg),
        .stat    (hstat),
        .tbl_wr  (twr)
    );

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        assign lane_use[g] = (g == 0) ? 1'b1 : mode_reg;

        hieq_lane u_lane (
            .aclk     (aclk),
            .tbl_wr   (twr),
            .rd_en    (map_go),
            .rd_addr  (lane_addr[g]),
            .use_map  (lane_use[g]),
            .out_data (lane_out[g])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = is_map ? ST_MAP : ST_CNT_RD;
                end
            end
            ST_CNT_RD: state_next = ST_CNT_WR;
            ST_CNT_WR: state_next = last_reg ? ST_BUILD : ST_IDLE;
            ST_BUILD: begin
                if (hstat.build_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MAP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready          = (state_reg == ST_IDLE);
        map_go            = accept && is_map;
        hctrl.cnt_rd      = (state_reg == ST_CNT_RD);
        hctrl.cnt_wr      = (state_reg == ST_CNT_WR);
        hctrl.build_start = (state_reg == ST_CNT_WR) && last_reg;
        out_load          = (state_reg == ST_MAP) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            m_user_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
                m_user_reg  <= hstat.overflow;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            bin_reg  <= bin_calc;
            last_reg <= s_tlast;
        end
        if (out_load) begin
            m_data_reg <= lane_out;
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== hw/rtl/hieq_ram.sv =====
// ----------------------------------------------------------------------------
// hieq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module hieq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hieq_div.sv =====
// ----------------------------------------------------------------------------
// hieq_div
// restoring divider, one quotient bit per cycle, quotient saturated to 8 bits
// ----------------------------------------------------------------------------
module hieq_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [hieq_pkg::NUM_BITS-1:0]    num,
    input  logic [hieq_pkg::COUNT_BITS-1:0]  den,
    output logic                             done,
    output logic [hieq_pkg::PIX_BITS-1:0]    quo
);
    import hieq_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic                 zero_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [NUM_BITS-1:0]  rem_reg;
    logic [NUM_BITS-1:0]  dsr_reg;
    logic [QUO_STEPS-1:0] quo_reg;
    logic                 fits;

    assign fits = (rem_reg >= dsr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (step_reg == '0)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num;
            dsr_reg  <= NUM_BITS'(den) << PIX_BITS;
            quo_reg  <= '0;
            step_reg <= STEP_BITS'(QUO_STEPS - 1);
            zero_reg <= (den == '0);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsr_reg;
            end
            dsr_reg  <= dsr_reg >> 1;
            quo_reg  <= {quo_reg[QUO_STEPS-2:0], fits};
            step_reg <= step_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quo  = zero_reg ? '0 :
                  quo_reg[QUO_STEPS-1] ? '1 : quo_reg[PIX_BITS-1:0];

endmodule

// ===== hw/rtl/hieq_hist.sv =====
// ----------------------------------------------------------------------------
// hieq_hist
// histogram counting with saturation and transfer table build sequencer
// ----------------------------------------------------------------------------
module hieq_hist (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  hieq_pkg::hist_ctrl_t           ctrl,
    input  logic [hieq_pkg::BIN_BITS-1:0]  bin,
    output hieq_pkg::hist_stat_t           stat,
    output hieq_pkg::tbl_wr_t              tbl_wr
);
    import hieq_pkg::*;

    bld_state_t            bstate_reg, bstate_next;
    logic [BIN_COUNT-1:0]  valid_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic                  overflow_reg;
    logic [CUM_BITS-1:0]   cum_reg;
    logic [BIN_BITS-1:0]   idx_reg;

    logic                  ram_re;
    logic [BIN_BITS-1:0]   ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] bld_count;
    logic                  bin_sat;
    logic                  total_sat;
    logic [COUNT_BITS-1:0] bin_wdata;

    logic                  div_start;
    logic                  div_done;
    logic [NUM_BITS-1:0]   div_num;
    logic [PIX_BITS-1:0]   div_quo;
    logic                  finish;

    hieq_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BIN_COUNT)
    ) u_bins (
        .aclk  (aclk),
        .we    (ctrl.cnt_wr),
        .waddr (bin),
        .wdata (bin_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hieq_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (total_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign cur_count = valid_reg[bin] ? ram_rdata : '0;
    assign bld_count = valid_reg[idx_reg] ? ram_rdata : '0;
    assign bin_sat   = (cur_count == COUNT_MAX);
    assign total_sat = (total_reg == COUNT_MAX);
    assign bin_wdata = bin_sat ? cur_count : cur_count + 1'b1;
    assign div_num   = {cum_reg, PIX_BITS'(0)} - NUM_BITS'(cum_reg);

    always_comb begin
        bstate_next = bstate_reg;
        case (bstate_reg)
            BS_IDLE: begin
                if (ctrl.build_start) begin
                    bstate_next = BS_READ;
                end
            end
            BS_READ:  bstate_next = BS_ACC;
            BS_ACC:   bstate_next = BS_SCALE;
            BS_SCALE: bstate_next = BS_DIV;
            BS_DIV: begin
                if (div_done) begin
                    bstate_next = (idx_reg == BIN_LAST) ? BS_IDLE : BS_READ;
                end
            end
            default:  bstate_next = BS_IDLE;
        endcase
    end

    always_comb begin
        ram_re      = ctrl.cnt_rd || (bstate_reg == BS_READ);
        ram_raddr   = ctrl.cnt_rd ? bin : idx_reg;
        div_start   = (bstate_reg == BS_SCALE);
        tbl_wr.we   = (bstate_reg == BS_DIV) && div_done;
        tbl_wr.addr = idx_reg;
        tbl_wr.data = div_quo;
        finish      = tbl_wr.we && (idx_reg == BIN_LAST);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bstate_reg   <= BS_IDLE;
            valid_reg    <= '0;
            total_reg    <= '0;
            overflow_reg <= 1'b0;
        end else begin
            bstate_reg <= bstate_next;
            if (ctrl.cnt_wr) begin
                valid_reg[bin] <= 1'b1;
                if (!total_sat) begin
                    total_reg <= total_reg + 1'b1;
                end
                if (bin_sat || total_sat) begin
                    overflow_reg <= 1'b1;
                end
            end else if (finish) begin
                valid_reg <= '0;
                total_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.build_start) begin
            cum_reg <= '0;
            idx_reg <= '0;
        end else begin
            if (bstate_reg == BS_ACC) begin
                cum_reg <= cum_reg + CUM_BITS'(bld_count);
            end
            if (tbl_wr.we) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign stat.build_done = finish;
    assign stat.overflow   = overflow_reg;

endmodule

// ===== hw/rtl/hieq_lane.sv =====
// ----------------------------------------------------------------------------
// hieq_lane
// one lookup lane: a copy of the transfer table and a pass-through select
// ----------------------------------------------------------------------------
module hieq_lane (
    input  logic                           aclk,
    input  hieq_pkg::tbl_wr_t              tbl_wr,
    input  logic                           rd_en,
    input  logic [hieq_pkg::PIX_BITS-1:0]  rd_addr,
    input  logic                           use_map,
    output logic [hieq_pkg::PIX_BITS-1:0]  out_data
);
    import hieq_pkg::*;

    logic [PIX_BITS-1:0] tbl_rdata;
    logic [PIX_BITS-1:0] pass_reg;
    logic                use_reg;

    hieq_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (BIN_COUNT)
    ) u_tbl (
        .aclk  (aclk),
        .we    (tbl_wr.we),
        .waddr (tbl_wr.addr),
        .wdata (tbl_wr.data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (tbl_rdata)
    );

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            pass_reg <= rd_addr;
            use_reg  <= use_map;
        end
    end

    assign out_data = use_reg ? tbl_rdata : pass_reg;

endmodule

// ===== hw/rtl/hieq_chk.sv =====
// ----------------------------------------------------------------------------
// hieq_chk
// port-level checks of the histogram equalizer, bound to the top level
// ----------------------------------------------------------------------------
module hieq_chk (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [hieq_pkg::DATA_BITS-1:0]  m_tdata,
    input  logic                            m_tlast,
    input  logic                            m_tuser
);
    import hieq_pkg::*;

    // overflow flag is sticky between resets
    a_overflow_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> !$fell(m_tuser))
        else $error("count_overflow dropped without reset");

    // one item at a time: ready drops after each accepted item
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item still in work");

    // a count item never produces a result
    a_count_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (opcode_t'(s_tuser) == OP_COUNT) |=> !$rose(m_tvalid))
        else $error("result appeared after a count item");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind histogram_equalizer_unit hieq_chk u_hieq_chk (.*);
